FILE: sv/zstl_pkg.sv
// package: types, codes and character helpers for the token lexer
package zstl_pkg;

  localparam int PositionBitsDefault = 32;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_WORD  = 4'd1,
    M_NUM   = 4'd2,
    M_STR   = 4'd3,
    M_ANG1  = 4'd4,
    M_ANG2  = 4'd5,
    M_OP1   = 4'd6,
    M_LINE  = 4'd7,
    M_BLOCK = 4'd8
  } lex_mode_t;

  typedef enum logic [3:0] {
    C_DEFAULT = 4'd0,
    C_KEYWORD = 4'd1,
    C_TYPE    = 4'd2,
    C_IDENT   = 4'd3,
    C_NUMBER  = 4'd4,
    C_STRING  = 4'd5,
    C_OPEN    = 4'd6,
    C_CLOSE   = 4'd7,
    C_PUNCT   = 4'd8,
    C_COMMENT = 4'd9
  } tok_class_t;

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic id_start(input logic [7:0] c);
    return (c == 8'h5f) || (c == 8'h40) || letter_char(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic [47:0] pack_word(input string s);
    logic [47:0] r;
    r = '0;
    for (int k = 0; k < 6; k++) begin
      if (k < s.len()) r[8*k +: 8] = s[k];
    end
    return r;
  endfunction

  // word class from the kept prefix, length and integer type flag
  function automatic tok_class_t word_class(input logic [47:0] w, input logic [2:0] n,
                                            input logic f);
    logic kw;
    logic ty;
    kw = ((n == 3'd3) && (w == pack_word("pub"))) ||
         ((n == 3'd5) && (w == pack_word("const"))) ||
         ((n == 3'd5) && (w == pack_word("union"))) ||
         ((n == 3'd4) && (w == pack_word("enum"))) ||
         ((n == 3'd6) && (w == pack_word("struct"))) ||
         ((n == 3'd2) && (w == pack_word("if"))) ||
         ((n == 3'd3) && (w == pack_word("var"))) ||
         ((n == 3'd5) && (w == pack_word("while"))) ||
         ((n == 3'd4) && (w == pack_word("true"))) ||
         ((n == 3'd5) && (w == pack_word("false"))) ||
         ((n == 3'd6) && (w == pack_word("return"))) ||
         ((n == 3'd5) && (w == pack_word("error"))) ||
         ((n == 3'd4) && (w == pack_word("test"))) ||
         ((n == 3'd3) && (w == pack_word("try"))) ||
         ((n == 3'd6) && (w == pack_word("switch"))) ||
         ((n == 3'd4) && (w == pack_word("else"))) ||
         ((n == 3'd4) && (w == pack_word("null"))) ||
         ((n == 3'd3) && (w == pack_word("for"))) ||
         ((n == 3'd2) && (w == pack_word("fn")));
    ty = ((n == 3'd5) && (w == pack_word("usize"))) ||
         ((n == 3'd5) && (w == pack_word("isize"))) ||
         ((n == 3'd4) && (w == pack_word("void"))) ||
         (f && (n >= 3'd2));
    if (kw) return C_KEYWORD;
    if (ty) return C_TYPE;
    return C_IDENT;
  endfunction

  typedef struct packed {
    logic       valid;
    logic       at_next;
    tok_class_t cls;
  } tok_t;

endpackage

FILE: sv/zig_syntax_token_lexer.sv
// top level of the streaming token lexer
// One byte per cycle is accepted while output room lasts; a byte can give up to two tokens,
// which leave through a two-entry queue one per cycle while out_stall is low, so bytes that close
// a token and open a one-byte token hold the input off while the queue holds both. The first token
// of an accepted byte appears at the outputs in the next cycle, from the queue register driving
// the outputs; in_stall follows out_stall combinationally when the queue holds one word.
module zig_syntax_token_lexer import zstl_pkg::*; #(
  parameter int PositionBits = PositionBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] token_start,
  output logic [31:0] token_end,
  output logic [3:0]  token_class,
  output logic        last_of_run
);

  tok_t                    tok_a, tok_b;
  logic [PositionBits-1:0] start_a, start_b, pos, pos_inc;
  logic [63:0]             sa, sb, ea, pe, pn;
  logic [68:0]             da, db, dq;
  logic                    room, step;

  assign in_stall = !room;
  assign step     = in_valid && room;
  assign pos_inc  = pos + PositionBits'(1);

  zstl_core #(.PositionBits(PositionBits)) u_core (
    .clk, .rst, .step, .text_byte, .buffer_end,
    .tok_a, .tok_b, .start_a, .start_b, .pos
  );

  assign sa = 64'(start_a);
  assign sb = 64'(start_b);
  assign pe = 64'(pos);
  assign pn = 64'(pos_inc);
  assign ea = tok_a.at_next ? pn : pe;
  assign da = {sa[31:0], ea[31:0], tok_a.cls, !tok_b.valid};
  assign db = {sb[31:0], pn[31:0], tok_b.cls, 1'b1};

  zstl_outq u_outq (
    .clk, .rst,
    .push_a(step && tok_a.valid), .data_a(da),
    .push_b(step && tok_b.valid), .data_b(db),
    .room, .valid(out_valid), .stall(out_stall), .data(dq)
  );

  assign token_start = dq[68:37];
  assign token_end   = dq[36:5];
  assign token_class = dq[4:1];
  assign last_of_run = dq[0];

endmodule

FILE: sv/zstl_core.sv
// lexer state and per-byte token decisions, up to two tokens per byte
module zstl_core import zstl_pkg::*; #(
  parameter int PositionBits = PositionBitsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              text_byte,
  input  logic                    buffer_end,
  output tok_t                    tok_a,
  output tok_t                    tok_b,
  output logic [PositionBits-1:0] start_a,
  output logic [PositionBits-1:0] start_b,
  output logic [PositionBits-1:0] pos
);

  lex_mode_t             mode, mode_next;
  logic [PositionBits-1:0] start_pos, start_pos_next;
  logic [47:0]           prefix, prefix_next;
  logic [2:0]            wlen, wlen_next;
  logic                  itf, itf_next;
  logic [7:0]            opench, opench_next;
  logic                  esc, esc_next;
  logic                  restart;
  logic                  c_digit, c_idcont, c_op;
  logic [47:0]           ins;

  assign c_digit  = digit_char(text_byte);
  assign c_idcont = id_start(text_byte) || c_digit;
  assign c_op = (text_byte == ":") || (text_byte == "=") || (text_byte == "!") ||
                (text_byte == "?") || (text_byte == "+") || (text_byte == "-") ||
                (text_byte == "*") || (text_byte == "/") || (text_byte == "%") ||
                (text_byte == "^") || (text_byte == "|") || (text_byte == "&");

  always_comb begin
    ins = '0;
    for (int k = 0; k < 6; k++) begin
      if (wlen == 3'(k)) ins[8*k +: 8] = text_byte;
    end
  end

  always_comb begin
    mode_next      = mode;
    start_pos_next = start_pos;
    prefix_next    = prefix;
    wlen_next      = wlen;
    itf_next       = itf;
    opench_next    = opench;
    esc_next       = esc;
    restart        = 1'b0;
    tok_a          = '{valid: 1'b0, at_next: 1'b1, cls: C_PUNCT};
    tok_b          = '{valid: 1'b0, at_next: 1'b1, cls: C_PUNCT};
    unique case (mode)
      M_WORD: begin
        if (c_idcont) begin
          prefix_next = prefix | ins;
          if (wlen < 3'd7) wlen_next = wlen + 3'd1;
          itf_next = itf && c_digit;
          tok_a = '{valid: buffer_end, at_next: 1'b1,
                    cls: word_class(prefix_next, wlen_next, itf_next)};
        end else begin
          tok_a = '{valid: 1'b1, at_next: 1'b0, cls: word_class(prefix, wlen, itf)};
          restart = 1'b1;
        end
      end
      M_NUM: begin
        if (c_digit || letter_char(text_byte)) begin
          tok_a = '{valid: buffer_end, at_next: 1'b1, cls: C_NUMBER};
        end else begin
          tok_a = '{valid: 1'b1, at_next: 1'b0, cls: C_NUMBER};
          restart = 1'b1;
        end
      end
      M_STR: begin
        if (esc) begin
          esc_next = 1'b0;
          tok_a = '{valid: buffer_end, at_next: 1'b1, cls: C_STRING};
        end else if (text_byte == opench) begin
          tok_a = '{valid: 1'b1, at_next: 1'b1, cls: C_STRING};
          mode_next = M_IDLE;
        end else begin
          esc_next = (text_byte == 8'h5c);
          tok_a = '{valid: buffer_end, at_next: 1'b1, cls: C_STRING};
        end
      end
      M_ANG1, M_ANG2: begin
        if (text_byte == "=") begin
          tok_a = '{valid: 1'b1, at_next: 1'b1, cls: C_PUNCT};
          mode_next = M_IDLE;
        end else if (mode == M_ANG1 && text_byte == opench) begin
          mode_next = M_ANG2;
          tok_a = '{valid: buffer_end, at_next: 1'b1, cls: C_PUNCT};
        end else begin
          tok_a = '{valid: 1'b1, at_next: 1'b0, cls: C_PUNCT};
          restart = 1'b1;
        end
      end
      M_OP1: begin
        if (text_byte == "=") begin
          tok_a = '{valid: 1'b1, at_next: 1'b1, cls: C_PUNCT};
          mode_next = M_IDLE;
        end else if (text_byte == "/") begin
          mode_next = M_LINE;
          tok_a = '{valid: buffer_end, at_next: 1'b1, cls: C_COMMENT};
        end else if (text_byte == "*") begin
          mode_next = M_BLOCK;
          esc_next = 1'b1;
          tok_a = '{valid: buffer_end, at_next: 1'b1, cls: C_COMMENT};
        end else if ((opench == "+" || opench == "-" || opench == "|" || opench == "&") &&
                     text_byte == opench) begin
          tok_a = '{valid: 1'b1, at_next: 1'b1, cls: C_PUNCT};
          mode_next = M_IDLE;
        end else begin
          tok_a = '{valid: 1'b1, at_next: 1'b0, cls: C_PUNCT};
          restart = 1'b1;
        end
      end
      M_LINE: begin
        if (text_byte == 8'h0a) begin
          tok_a = '{valid: 1'b1, at_next: 1'b0, cls: C_COMMENT};
          mode_next = M_IDLE;
        end else begin
          tok_a = '{valid: buffer_end, at_next: 1'b1, cls: C_COMMENT};
        end
      end
      M_BLOCK: begin
        if (esc && text_byte == "/") begin
          esc_next = 1'b0;
          tok_a = '{valid: 1'b1, at_next: 1'b1, cls: C_COMMENT};
          mode_next = M_IDLE;
        end else begin
          esc_next = (text_byte == "*");
          tok_a = '{valid: buffer_end, at_next: 1'b1, cls: C_COMMENT};
        end
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      mode_next = M_IDLE;
      if (!is_space(text_byte)) begin
        start_pos_next = pos;
        if (id_start(text_byte)) begin
          mode_next   = M_WORD;
          prefix_next = {40'd0, text_byte};
          wlen_next   = 3'd1;
          itf_next    = (text_byte == "i") || (text_byte == "u");
          tok_b = '{valid: buffer_end, at_next: 1'b1,
                    cls: word_class({40'd0, text_byte}, 3'd1, itf_next)};
        end else if (c_digit) begin
          mode_next = M_NUM;
          tok_b = '{valid: buffer_end, at_next: 1'b1, cls: C_NUMBER};
        end else if (text_byte == 8'h22 || text_byte == 8'h27) begin
          mode_next   = M_STR;
          opench_next = text_byte;
          esc_next    = 1'b0;
          tok_b = '{valid: buffer_end, at_next: 1'b1, cls: C_STRING};
        end else if (text_byte == "{" || text_byte == "[" || text_byte == "(") begin
          tok_b = '{valid: 1'b1, at_next: 1'b1, cls: C_OPEN};
        end else if (text_byte == "}" || text_byte == "]" || text_byte == ")") begin
          tok_b = '{valid: 1'b1, at_next: 1'b1, cls: C_CLOSE};
        end else if (text_byte == "<" || text_byte == ">") begin
          mode_next   = M_ANG1;
          opench_next = text_byte;
          tok_b = '{valid: buffer_end, at_next: 1'b1, cls: C_PUNCT};
        end else if (c_op) begin
          mode_next   = M_OP1;
          opench_next = text_byte;
          tok_b = '{valid: buffer_end, at_next: 1'b1, cls: C_PUNCT};
        end else if (text_byte == ";" || text_byte == "," || text_byte == ".") begin
          tok_b = '{valid: 1'b1, at_next: 1'b1, cls: C_PUNCT};
        end else begin
          tok_b = '{valid: 1'b1, at_next: 1'b1, cls: C_DEFAULT};
        end
      end
    end
    if (buffer_end) begin
      mode_next = M_IDLE;
      esc_next  = 1'b0;
    end
  end

  assign start_a = start_pos;
  assign start_b = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      pos       <= '0;
      start_pos <= '0;
      prefix    <= '0;
      wlen      <= '0;
      itf       <= 1'b0;
      opench    <= '0;
      esc       <= 1'b0;
    end else if (step) begin
      mode      <= mode_next;
      pos       <= buffer_end ? '0 : pos + PositionBits'(1);
      start_pos <= start_pos_next;
      prefix    <= prefix_next;
      wlen      <= wlen_next;
      itf       <= itf_next;
      opench    <= opench_next;
      esc       <= esc_next;
    end
  end

endmodule

FILE: sv/zstl_outq.sv
// two-entry token queue feeding the output register
module zstl_outq import zstl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_a,
  input  logic [68:0] data_a,
  input  logic        push_b,
  input  logic [68:0] data_b,
  output logic        room,
  output logic        valid,
  input  logic        stall,
  output logic [68:0] data
);

  logic [68:0] q0, q1, q0_next, q1_next;
  logic [1:0]  cnt, cnt_next;
  logic        pop;
  logic [1:0]  base;
  logic [1:0]  pb_idx;

  // two slots; a new byte is taken only when both are free after this cycle's pop
  assign pop   = valid && !stall;
  assign room  = (cnt == 2'd0) || (cnt == 2'd1 && pop);
  assign valid = cnt != 2'd0;
  assign data  = q0;
  assign base  = cnt - {1'b0, pop};
  assign pb_idx = base + {1'b0, push_a};
  assign cnt_next = base + {1'b0, push_a} + {1'b0, push_b};

  always_comb begin
    q0_next = pop ? q1 : q0;
    q1_next = q1;
    if (push_a) begin
      if (base == 2'd0) q0_next = data_a;
      else q1_next = data_a;
    end
    if (push_b) begin
      if (pb_idx == 2'd0) q0_next = data_b;
      else q1_next = data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

endmodule

FILE: sv/zstl_checker.sv
// port-level checks for the token lexer
module zstl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] token_class
);

  a_class: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_class <= 4'd9) else $error("token class out of range");

  a_idle_after_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("word out after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("stalled word dropped");

  a_no_in_nothing: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("input stalled with empty output");

endmodule

bind zig_syntax_token_lexer zstl_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .token_class
);
